// File: rtl/core/fmc_pkg.sv
`default_nettype none
package fmc_pkg;

  localparam int LEN_W  = 11;
  localparam int BYTE_W = 8;
  localparam int OP_W   = 3;
  localparam int STAT_W = 3;

  localparam int BYTE_DEPTH_DEF   = 1024;
  localparam int RECORD_DEPTH_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_SEND_START = 3'd0,
    OP_SEND_BYTE  = 3'd1,
    OP_RECV_START = 3'd2,
    OP_RECV_BYTE  = 3'd3,
    OP_CLOSE      = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_CLOSED      = 3'd1,
    ST_NO_RECORD   = 3'd2,
    ST_NO_BYTES    = 3'd3,
    ST_WOULD_BLOCK = 3'd4,
    ST_TOO_SMALL   = 3'd5,
    ST_SEQUENCE    = 3'd6
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted item and read both rings at their tails
    logic exec;     // apply the item and load the result register
  } fmc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } fmc_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/fmc_ctrl.sv
`default_nettype none
module fmc_ctrl
  import fmc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire fmc_stat_t stat,
  output fmc_cmd_t       cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  assign s_tready    = (state == IDLE);
  assign cmd.capture = s_tvalid && (state == IDLE);
  assign cmd.exec    = (state == EXEC) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (s_tvalid) state <= EXEC;
        end
        EXEC: begin
          // hold until the result register can take the result
          if (stat.out_free) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/fmc_datapath.sv
`default_nettype none
module fmc_datapath
  import fmc_pkg::*;
#(
  parameter int BYTE_DEPTH   = BYTE_DEPTH_DEF,
  parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fmc_cmd_t          cmd,
  output fmc_stat_t              stat,
  input  wire logic [OP_W-1:0]   in_op,
  input  wire logic [LEN_W-1:0]  in_msg_len,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic [LEN_W-1:0]  in_recv_room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [LEN_W-1:0]       out_len,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last,
  output logic                   out_readable,
  output logic                   out_writable,
  output logic                   out_is_closed
);

  localparam int BI_W  = $clog2(BYTE_DEPTH);
  localparam int BU_W  = $clog2(BYTE_DEPTH + 1);
  localparam int RI_W  = $clog2(RECORD_DEPTH);
  localparam int RU_W  = $clog2(RECORD_DEPTH + 1);
  localparam int CMP_W = (BU_W > LEN_W) ? BU_W : LEN_W;

  localparam logic [BI_W-1:0]  BYTE_LAST   = BI_W'(BYTE_DEPTH - 1);
  localparam logic [RI_W-1:0]  RECORD_LAST = RI_W'(RECORD_DEPTH - 1);
  localparam logic [BU_W-1:0]  BYTE_FULL   = BU_W'(BYTE_DEPTH);
  localparam logic [RU_W-1:0]  RECORD_FULL = RU_W'(RECORD_DEPTH);

  logic [BYTE_W-1:0] byte_mem [BYTE_DEPTH];
  logic [LEN_W-1:0]  rec_mem  [RECORD_DEPTH];

  logic [BYTE_W-1:0] byte_rd;
  logic [LEN_W-1:0]  rec_rd;

  logic [OP_W-1:0]   op;
  logic [LEN_W-1:0]  msg_len;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  recv_room;

  logic [BI_W-1:0]  byte_head, byte_tail;
  logic [BU_W-1:0]  byte_used;
  logic [RI_W-1:0]  record_head, record_tail;
  logic [RU_W-1:0]  record_used;
  logic             closed_flag;
  logic [LEN_W-1:0] send_left, send_total, recv_left;
  logic             send_active;

  logic [BI_W-1:0]  byte_head_next, byte_tail_next;
  logic [BU_W-1:0]  byte_used_next;
  logic [RI_W-1:0]  record_head_next, record_tail_next;
  logic [RU_W-1:0]  record_used_next;
  logic             closed_flag_next;
  logic [LEN_W-1:0] send_left_next, send_total_next, recv_left_next;
  logic             send_active_next;

  logic              byte_wr, rec_wr;
  logic [LEN_W-1:0]  rec_wr_len;
  status_t           status_c;
  logic [LEN_W-1:0]  len_c;
  logic [BYTE_W-1:0] byte_c;
  logic              last_c;
  logic [CMP_W-1:0]  free_bytes;

  assign stat.out_free = !out_valid || out_ready;
  assign free_bytes    = CMP_W'(BYTE_FULL - byte_used);

  // latch the item and read both rings at their current tails
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= in_op;
      msg_len   <= in_msg_len;
      data_byte <= in_data_byte;
      recv_room <= in_recv_room;
      byte_rd   <= byte_mem[byte_tail];
      rec_rd    <= rec_mem[record_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && byte_wr) byte_mem[byte_head] <= data_byte;
    if (cmd.exec && rec_wr) rec_mem[record_head] <= rec_wr_len;
  end

  always_comb begin
    byte_head_next   = byte_head;
    byte_tail_next   = byte_tail;
    byte_used_next   = byte_used;
    record_head_next = record_head;
    record_tail_next = record_tail;
    record_used_next = record_used;
    closed_flag_next = closed_flag;
    send_left_next   = send_left;
    send_total_next  = send_total;
    recv_left_next   = recv_left;
    send_active_next = send_active;
    byte_wr          = 1'b0;
    rec_wr           = 1'b0;
    rec_wr_len       = send_total;
    status_c         = ST_OK;
    len_c            = '0;
    byte_c           = '0;
    last_c           = 1'b0;

    unique case (op)
      OP_SEND_START: begin
        if (send_active) begin
          status_c = ST_SEQUENCE;
        end else if (closed_flag) begin
          status_c = ST_CLOSED;
        end else if (record_used == RECORD_FULL) begin
          status_c = ST_NO_RECORD;
        end else if (CMP_W'(msg_len) > free_bytes) begin
          status_c = ST_NO_BYTES;
        end else begin
          len_c            = msg_len;
          byte_used_next   = byte_used + BU_W'(msg_len);
          send_total_next  = msg_len;
          send_left_next   = msg_len;
          send_active_next = 1'b1;
          if (msg_len == '0) begin
            // empty message: commit now
            rec_wr           = 1'b1;
            rec_wr_len       = '0;
            record_head_next = (record_head == RECORD_LAST) ? '0 : record_head + 1'b1;
            record_used_next = record_used + 1'b1;
            send_active_next = 1'b0;
            send_left_next   = '0;
          end
        end
      end
      OP_SEND_BYTE: begin
        if (!send_active || send_left == '0) begin
          status_c = ST_SEQUENCE;
        end else begin
          byte_wr        = 1'b1;
          byte_head_next = (byte_head == BYTE_LAST) ? '0 : byte_head + 1'b1;
          send_left_next = send_left - 1'b1;
          if (send_left == LEN_W'(1)) begin
            len_c            = send_total;
            rec_wr           = 1'b1;
            record_head_next = (record_head == RECORD_LAST) ? '0 : record_head + 1'b1;
            record_used_next = record_used + 1'b1;
            send_active_next = 1'b0;
            send_left_next   = '0;
          end
        end
      end
      OP_RECV_START: begin
        if (closed_flag) begin
          status_c = ST_CLOSED;
        end else if (recv_left != '0) begin
          status_c = ST_SEQUENCE;
        end else if (record_used == '0) begin
          status_c = ST_WOULD_BLOCK;
        end else if (recv_room < rec_rd) begin
          status_c = ST_TOO_SMALL;
        end else begin
          record_tail_next = (record_tail == RECORD_LAST) ? '0 : record_tail + 1'b1;
          record_used_next = record_used - 1'b1;
          recv_left_next   = rec_rd;
          len_c            = rec_rd;
        end
      end
      OP_RECV_BYTE: begin
        if (recv_left == '0 || byte_used == '0) begin
          status_c = ST_SEQUENCE;
        end else begin
          byte_c         = byte_rd;
          byte_tail_next = (byte_tail == BYTE_LAST) ? '0 : byte_tail + 1'b1;
          byte_used_next = byte_used - 1'b1;
          recv_left_next = recv_left - 1'b1;
          last_c         = (recv_left == LEN_W'(1));
        end
      end
      OP_CLOSE: begin
        closed_flag_next = 1'b1;
      end
      default: begin
        status_c = ST_SEQUENCE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_head   <= '0;
      byte_tail   <= '0;
      byte_used   <= '0;
      record_head <= '0;
      record_tail <= '0;
      record_used <= '0;
      closed_flag <= 1'b0;
      send_left   <= '0;
      send_total  <= '0;
      send_active <= 1'b0;
      recv_left   <= '0;
    end else if (cmd.exec) begin
      byte_head   <= byte_head_next;
      byte_tail   <= byte_tail_next;
      byte_used   <= byte_used_next;
      record_head <= record_head_next;
      record_tail <= record_tail_next;
      record_used <= record_used_next;
      closed_flag <= closed_flag_next;
      send_left   <= send_left_next;
      send_total  <= send_total_next;
      send_active <= send_active_next;
      recv_left   <= recv_left_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status    <= status_c;
      out_len       <= len_c;
      out_byte      <= byte_c;
      out_last      <= last_c;
      out_readable  <= (record_used_next != '0);
      out_writable  <= (record_used_next != RECORD_FULL);
      out_is_closed <= closed_flag_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/framed_message_channel_top.sv
// Framed message channel: a mailbox of length-framed messages held in a byte
// ring and a ring of length records.
// Input stream: s_tuser carries the operation (send start, send byte, receive
// start, receive byte, close); s_tdata carries msg_len, data_byte and
// recv_room. Each input transfer produces exactly one output transfer.
// Output stream: m_tuser carries the status code, m_tlast marks the final
// byte of a received message, m_tdata carries out_len, out_byte and the
// readable, writable and closed flags as they stand after the operation.
// Timing: an item is accepted in the idle state, which latches it and reads
// both ring memories at their tails into registers; it is applied in the
// execute state, which loads the output register. The control state machine
// takes one item at a time and accepts no new item until the last is applied.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls with a result pending, the following item
// holds in the execute step until the output register frees.
// Reset clears all pointers, counters and flags and empties the output; ring
// contents are not cleared and need no clearing pass.
`default_nettype none
module framed_message_channel_top
  import fmc_pkg::*;
#(
  parameter int BYTE_DEPTH   = BYTE_DEPTH_DEF,
  parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // msg_len[10:0], data_byte[18:11], recv_room[29:19]
  input  wire logic [2:0]  s_tuser,   // op[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // out_len[10:0], out_byte[18:11], readable[19],
                                      // writable[20], is_closed[21]
  output logic [2:0]       m_tuser,   // status[2:0]
  output logic             m_tlast
);

  fmc_cmd_t  cmd;
  fmc_stat_t stat;

  logic [LEN_W-1:0]  out_len;
  logic [BYTE_W-1:0] out_byte;
  logic              out_readable, out_writable, out_is_closed;

  fmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fmc_datapath #(
    .BYTE_DEPTH   (BYTE_DEPTH),
    .RECORD_DEPTH (RECORD_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (s_tuser),
    .in_msg_len    (s_tdata[10:0]),
    .in_data_byte  (s_tdata[18:11]),
    .in_recv_room  (s_tdata[29:19]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_status    (m_tuser),
    .out_len       (out_len),
    .out_byte      (out_byte),
    .out_last      (m_tlast),
    .out_readable  (out_readable),
    .out_writable  (out_writable),
    .out_is_closed (out_is_closed)
  );

  assign m_tdata = {2'b00, out_is_closed, out_writable, out_readable, out_byte, out_len};

endmodule
`default_nettype wire
